// ===== rtl/core/fksc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fksc_pkg: shared types and constants of the keyed slot cache
// Word layouts of the stream channels, request codes, sequencer states and
// the status word of the tag scan unit.
// ----------------------------------------------------------------------------
package fksc_pkg;

	// request kinds (s_tuser)
	localparam int REQ_W = 2;
	typedef enum logic [REQ_W-1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_UPDATE = 2'd2
	} req_t;

	// input word layout (s_tdata)
	localparam int KEY_W      = 64;
	localparam int KEY_LSB    = 0;
	localparam int VKEY_LSB   = 64;
	localparam int VOK_BIT    = 128;
	localparam int HASV_BIT   = 129;
	localparam int HANDLE_W   = 32;
	localparam int HANDLE_LSB = 130;
	localparam int META_W     = 32;
	localparam int META_LSB   = 162;
	localparam int S_TDATA_W  = 200;

	// result word layout (m_tdata)
	localparam int FHANDLE_LSB = 0;
	localparam int FMETA_LSB   = 32;
	localparam int SIDX_W      = 4;
	localparam int SIDX_LSB    = 64;
	localparam int M_TDATA_W   = 72;
	localparam int M_PAD_W     = M_TDATA_W - SIDX_LSB - SIDX_W;

	// ring size register
	localparam int               RING_W     = 5;
	localparam logic [RING_W-1:0] RING_RESET = 5'd16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH_K,
		ST_SRCH_V,
		ST_WR,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic done;
		logic hit;
	} scan_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/fifo_keyed_slot_cache.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_keyed_slot_cache: fully associative keyed slot cache, FIFO replacement
// Lookup, insert and metadata update on RING_DEPTH slots, with a second
// search under the varied key for vary-marked entries.
//
//  channel  | signals                              | direction
//  ---------+--------------------------------------+----------
//  request  | s_tvalid s_tready s_tdata s_tuser    | in
//  result   | m_tvalid m_tready m_tdata m_tuser    | out
//  config   | cfg_valid cfg_ready cfg_data         | in
//
// One request word at a time. Each search sweeps the slot memory through one
// shared tag comparator, one slot per cycle. A word goes through 0, 1 or 2
// searches and 0, 1 or 2 slot writes before its response. After reset all
// slots are invalid and the ring size is 16; no clearing pass. The result
// sits in an output register and a stalled result holds the sequencer in its
// response state.
// ----------------------------------------------------------------------------
module fifo_keyed_slot_cache #(
	parameter int RING_DEPTH  = 16,
	parameter int KEY_BITS    = 64,
	parameter int HANDLE_BITS = 32
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_tvalid,
	output logic                            s_tready,
	// key[63:0], var_key[127:64], var_key_ok[128], response_has_vary[129],
	// entry_handle[161:130], entry_meta[193:162], zero pad
	input  wire  [fksc_pkg::S_TDATA_W-1:0] s_tdata,
	// req_type[1:0]
	input  wire  [fksc_pkg::REQ_W-1:0]     s_tuser,
	output logic                            m_tvalid,
	input  wire                             m_tready,
	// found_handle[31:0], found_meta[63:32], slot_index[67:64], zero pad
	output logic [fksc_pkg::M_TDATA_W-1:0] m_tdata,
	// success[0]
	output logic [0:0]                      m_tuser,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire  [fksc_pkg::RING_W-1:0]    cfg_data
);

	import fksc_pkg::*;

	localparam int PW       = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int EWD      = (PW + 1 > RING_W) ? PW + 1 : RING_W;
	localparam int ENT_W    = KEY_BITS + HANDLE_BITS + META_W + 1;
	localparam int TAG_LSB  = 0;
	localparam int PAY_LSB  = KEY_BITS;
	localparam int MET_LSB  = KEY_BITS + HANDLE_BITS;
	localparam int MARK_BIT = ENT_W - 1;

	state_t state_q, state_d;

	logic [REQ_W-1:0]       req_q;
	logic [KEY_BITS-1:0]    key_q;
	logic [KEY_BITS-1:0]    vkey_q;
	logic                   vok_q;
	logic                   hasv_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic [META_W-1:0]      meta_q;

	logic [PW-1:0]          wr_addr_q;
	logic [ENT_W-1:0]       wr_data_q;
	logic                   wr_mark_q;

	logic                   res_ok_q;
	logic [HANDLE_W-1:0]    res_handle_q;
	logic [META_W-1:0]      res_meta_q;
	logic [PW-1:0]          res_idx_q;

	logic                   out_ok_q;
	logic [HANDLE_W-1:0]    out_handle_q;
	logic [META_W-1:0]      out_meta_q;
	logic [PW-1:0]          out_idx_q;

	logic [RING_DEPTH-1:0]  valid_q;
	logic [PW-1:0]          ptr_q;
	logic [RING_W-1:0]      ring_q;

	logic                   accept;
	logic                   out_free;
	logic                   scan_start;
	logic                   ram_we;
	logic                   scan_rd_en;
	logic [PW-1:0]          scan_rd_addr;
	scan_stat_t             scan_stat;
	logic [PW-1:0]          hit_idx;
	logic [KEY_BITS-1:0]    scan_target;
	logic [ENT_W-1:0]       rd_ent;
	logic                   rd_mark;
	logic                   srch_done;

	logic [EWD-1:0]         ring_x;
	logic [EWD-1:0]         eff_x;
	logic [EWD-1:0]         ptr_x;
	logic [EWD-1:0]         repl_x;
	logic [EWD-1:0]         nxt_x;
	logic [PW-1:0]          repl_c;
	logic [PW-1:0]          ptr_nxt_c;

	logic                   ld_wr;
	logic                   ld_res;
	logic                   adv_ptr;
	logic                   set_mark;
	logic [PW-1:0]          wr_slot_c;
	logic [ENT_W-1:0]       wr_ent_c;
	logic [HANDLE_W-1:0]    res_handle_c;
	logic [META_W-1:0]      res_meta_c;

	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid || m_tready;
	assign cfg_ready = 1'b1;
	assign rd_mark   = rd_ent[MARK_BIT];
	assign srch_done = scan_stat.done && (state_q == ST_SRCH_K || state_q == ST_SRCH_V);

	// replacement slot
	always_comb begin
		ring_x = EWD'(ring_q);
		if (ring_x == '0) begin
			eff_x = EWD'(1);
		end else if (ring_x > EWD'(RING_DEPTH)) begin
			eff_x = EWD'(RING_DEPTH);
		end else begin
			eff_x = ring_x;
		end
		ptr_x  = EWD'(ptr_q);
		repl_x = (ptr_x >= eff_x) ? '0 : ptr_x;
		nxt_x  = repl_x + EWD'(1);
		if (nxt_x >= eff_x) begin
			nxt_x = '0;
		end
		repl_c    = PW'(repl_x);
		ptr_nxt_c = PW'(nxt_x);
	end

	assign scan_target = (state_q == ST_SRCH_V) ? vkey_q : key_q;

	fksc_scan #(
		.RING_DEPTH (RING_DEPTH),
		.KEY_BITS   (KEY_BITS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (scan_start),
		.target     (scan_target),
		.slot_valid (valid_q),
		.rd_tag     (rd_ent[TAG_LSB +: KEY_BITS]),
		.rd_en      (scan_rd_en),
		.rd_addr    (scan_rd_addr),
		.stat       (scan_stat),
		.hit_idx    (hit_idx)
	);

	fksc_ram #(
		.WIDTH (ENT_W),
		.DEPTH (RING_DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_addr_q),
		.wdata (wr_data_q),
		.re    (scan_rd_en),
		.raddr (scan_rd_addr),
		.rdata (rd_ent)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser == REQ_LOOKUP || s_tuser == REQ_UPDATE) begin
						state_d = ST_SRCH_K;
					end else if (s_tuser == REQ_INSERT) begin
						if (!s_tdata[HASV_BIT]) begin
							state_d = ST_SRCH_K;
						end else if (s_tdata[VOK_BIT]) begin
							state_d = ST_SRCH_V;
						end else begin
							state_d = ST_RESP;
						end
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_SRCH_K: begin
				if (scan_stat.done) begin
					if (req_q == REQ_LOOKUP || req_q == REQ_UPDATE) begin
						if (!scan_stat.hit) begin
							state_d = ST_RESP;
						end else if (rd_mark) begin
							state_d = vok_q ? ST_SRCH_V : ST_RESP;
						end else begin
							state_d = (req_q == REQ_UPDATE) ? ST_WR : ST_RESP;
						end
					end else if (hasv_q && scan_stat.hit) begin
						state_d = ST_RESP;
					end else begin
						state_d = ST_WR;
					end
				end
			end
			ST_SRCH_V: begin
				if (scan_stat.done) begin
					if (req_q == REQ_INSERT) begin
						state_d = ST_WR;
					end else if (scan_stat.hit && req_q == REQ_UPDATE) begin
						state_d = ST_WR;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_WR: begin
				if (req_q == REQ_INSERT && hasv_q && !wr_mark_q) begin
					state_d = ST_SRCH_K;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready   = 1'b0;
		ram_we     = 1'b0;
		scan_start = (state_d == ST_SRCH_K || state_d == ST_SRCH_V) && (state_d != state_q);
		unique case (state_q)
			ST_IDLE:   s_tready = 1'b1;
			ST_WR:     ram_we   = 1'b1;
			default: begin
				s_tready = 1'b0;
				ram_we   = 1'b0;
			end
		endcase
	end

	// slot write and result decisions at the end of a search
	always_comb begin
		ld_wr        = 1'b0;
		ld_res       = 1'b0;
		adv_ptr      = 1'b0;
		set_mark     = 1'b0;
		wr_slot_c    = scan_stat.hit ? hit_idx : repl_c;
		wr_ent_c     = {1'b0, meta_q, handle_q, key_q};
		res_handle_c = HANDLE_W'(handle_q);
		res_meta_c   = meta_q;
		if (srch_done) begin
			if (req_q == REQ_LOOKUP || req_q == REQ_UPDATE) begin
				if (scan_stat.hit && (state_q == ST_SRCH_V || !rd_mark)) begin
					ld_res       = 1'b1;
					ld_wr        = 1'b1;
					wr_slot_c    = hit_idx;
					wr_ent_c     = rd_ent;
					wr_ent_c[MET_LSB +: META_W] = meta_q;
					res_handle_c = HANDLE_W'(rd_ent[PAY_LSB +: HANDLE_BITS]);
					res_meta_c   = (req_q == REQ_UPDATE) ? meta_q : rd_ent[MET_LSB +: META_W];
				end
			end else if (req_q == REQ_INSERT) begin
				if (state_q == ST_SRCH_V || !hasv_q) begin
					ld_res  = 1'b1;
					ld_wr   = 1'b1;
					adv_ptr = !scan_stat.hit;
					wr_ent_c = {1'b0, meta_q, handle_q,
						(state_q == ST_SRCH_V) ? vkey_q : key_q};
				end else if (!scan_stat.hit) begin
					ld_res       = 1'b1;
					ld_wr        = 1'b1;
					adv_ptr      = 1'b1;
					set_mark     = 1'b1;
					wr_slot_c    = repl_c;
					wr_ent_c     = {1'b1, {META_W{1'b0}}, {HANDLE_BITS{1'b0}}, key_q};
					res_handle_c = '0;
					res_meta_c   = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			valid_q   <= '0;
			ptr_q     <= '0;
			ring_q    <= RING_RESET;
			wr_mark_q <= 1'b0;
			m_tvalid  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ram_we) begin
				valid_q[wr_addr_q] <= 1'b1;
			end
			if (adv_ptr) begin
				ptr_q <= ptr_nxt_c;
			end
			if (cfg_valid && cfg_ready) begin
				ring_q <= cfg_data;
			end
			if (accept) begin
				wr_mark_q <= 1'b0;
			end else if (set_mark) begin
				wr_mark_q <= 1'b1;
			end
			if (state_q == ST_RESP && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q        <= s_tuser;
			key_q        <= KEY_BITS'(s_tdata[KEY_LSB +: KEY_W]);
			vkey_q       <= KEY_BITS'(s_tdata[VKEY_LSB +: KEY_W]);
			vok_q        <= s_tdata[VOK_BIT];
			hasv_q       <= s_tdata[HASV_BIT];
			handle_q     <= HANDLE_BITS'(s_tdata[HANDLE_LSB +: HANDLE_W]);
			meta_q       <= s_tdata[META_LSB +: META_W];
			res_ok_q     <= 1'b0;
			res_handle_q <= '0;
			res_meta_q   <= '0;
			res_idx_q    <= '0;
		end else if (ld_res) begin
			res_ok_q     <= 1'b1;
			res_handle_q <= res_handle_c;
			res_meta_q   <= res_meta_c;
			res_idx_q    <= wr_slot_c;
		end
		if (ld_wr) begin
			wr_addr_q <= wr_slot_c;
			wr_data_q <= wr_ent_c;
		end
		if (state_q == ST_RESP && out_free) begin
			out_ok_q     <= res_ok_q;
			out_handle_q <= res_handle_q;
			out_meta_q   <= res_meta_q;
			out_idx_q    <= res_idx_q;
		end
	end

	assign m_tdata = {{M_PAD_W{1'b0}}, SIDX_W'(out_idx_q), out_meta_q, out_handle_q};
	assign m_tuser = out_ok_q;

	a_hit_slot_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_ok_q |-> valid_q[out_idx_q])
		else $error("result names a slot that was never written");

	a_result_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_RESP)
		else $error("result word raised outside the response state");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("accepted request word left the sequencer idle");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !scan_rd_en)
		else $error("slot write overlaps a scan read");

endmodule
`default_nettype wire

// ===== rtl/core/fksc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fksc_ram: generic slot memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fksc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire             clk,
	input  wire             we,
	input  wire  [AW-1:0]   waddr,
	input  wire  [WIDTH-1:0] wdata,
	input  wire             re,
	input  wire  [AW-1:0]   raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/fksc_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fksc_scan: shared tag compare unit
// Sweeps the slot memory one entry per cycle from slot 0 and stops at the
// lowest valid slot whose tag equals the target, or after the last slot.
// ----------------------------------------------------------------------------
module fksc_scan #(
	parameter int RING_DEPTH = 16,
	parameter int KEY_BITS   = 64,
	localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	input  wire  [KEY_BITS-1:0]      target,
	input  wire  [RING_DEPTH-1:0]    slot_valid,
	input  wire  [KEY_BITS-1:0]      rd_tag,
	output logic                     rd_en,
	output logic [PW-1:0]            rd_addr,
	output fksc_pkg::scan_stat_t     stat,
	output logic [PW-1:0]            hit_idx
);

	import fksc_pkg::*;

	logic          busy_q;
	logic          rd_vld_s1;
	logic [PW-1:0] cnt_q;
	logic [PW-1:0] addr_s1;
	logic          match_c;
	logic          last_c;

	assign match_c = rd_vld_s1 && slot_valid[addr_s1] && (rd_tag == target);
	assign last_c  = rd_vld_s1 && (addr_s1 == PW'(RING_DEPTH - 1));

	always_comb begin
		stat.done = busy_q && (match_c || last_c);
		stat.hit  = busy_q && match_c;
	end

	assign rd_en   = busy_q && !stat.done;
	assign rd_addr = cnt_q;
	assign hit_idx = addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			rd_vld_s1 <= 1'b0;
			cnt_q     <= '0;
		end else if (start) begin
			busy_q    <= 1'b1;
			rd_vld_s1 <= 1'b0;
			cnt_q     <= '0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (stat.done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			addr_s1 <= cnt_q;
		end
	end

endmodule
`default_nettype wire
